// ===== design/kth_missing_value_tracker_assert.svh =====
`ifndef KTH_MISSING_VALUE_TRACKER_ASSERT_SVH
`define KTH_MISSING_VALUE_TRACKER_ASSERT_SVH

// implication checked on every clock edge outside reset
`define KMVT_AST_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the cycle after the antecedent
`define KMVT_AST_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/kmvt_pkg.sv =====
package kmvt_pkg;

  localparam int VALUE_SPACE_DEF = 4096;
  localparam int BLOCK_SIZE_DEF  = 64;
  localparam int COUNT_BITS_DEF  = 16;

  localparam logic [11:0] LIMIT_RST  = 12'd4095;
  localparam logic [17:0] ANSWER_MAX = 18'h1FFFF;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_REM   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_RMW,
    S_BSUM,
    S_QBLK,
    S_QENT,
    S_DONE
  } state_t;

endpackage

// ===== design/kth_missing_value_tracker.sv =====
// Tracks an occurrence count per value and answers k-th missing value queries. All counts and
// missing bits live in one memory word per value, block sums in a second memory, each with a
// registered read. Requests are taken one at a time: in_tready is high only while idle, and
// the result sits in an output register, so a stalled result holds the next request back.
// Steps from the accepted request to out_tvalid:
// - add and remove read the value word, then write it back; when a missing bit changes, a
//   block sum update follows the write back
// - a query reads the block sums, then the entries, one read per cycle, up to NUM_BLOCKS
//   and BLOCK_SIZE of them
// - a query whose rank is zero or exceeds the missing total reads nothing
// - clear sweeps the value memory one entry per cycle
// in_tready rises together with out_tvalid. The same sweep runs after reset, during which no
// request is taken (limit writes on cfg_wr_en still are). BLOCK_SIZE must be a power of two.
`include "kth_missing_value_tracker_assert.svh"

module kth_missing_value_tracker
  import kmvt_pkg::*;
#(
  parameter int VALUE_SPACE = VALUE_SPACE_DEF,
  parameter int BLOCK_SIZE  = BLOCK_SIZE_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [11:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // value[11:0], rank[27:12], zero[31:28]
  input  logic [1:0]  in_tuser,   // op[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // answer[16:0], missing_total[28:17], error[29], zero[31:30]
);

  localparam int NUM_BLOCKS = (VALUE_SPACE + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int BLK_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int VAL_W      = $clog2(VALUE_SPACE);
  localparam int SH         = $clog2(BLOCK_SIZE);
  localparam int BSUM_W     = $clog2(BLOCK_SIZE + 1);
  localparam int WORD_W     = COUNT_BITS + 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [WORD_W-1:0] mem [VALUE_SPACE];
  logic [BSUM_W-1:0] bsm [NUM_BLOCKS];

  logic              mem_we, mem_re;
  logic [VAL_W-1:0]  mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata_r;
  logic              bs_we, bs_re;
  logic [BLK_W-1:0]  bs_waddr, bs_raddr;
  logic [BSUM_W-1:0] bs_wdata, bs_rdata_r;

  state_t            state_r, state_nxt;
  logic [11:0]       limit_r, clr_limit_r, clr_limit_nxt;
  logic [VAL_W-1:0]  total_r, total_nxt;
  logic [VAL_W-1:0]  v_r, v_nxt;
  logic [BLK_W-1:0]  blk_r, blk_nxt;
  logic [BSUM_W-1:0] bcnt_r, bcnt_nxt;
  logic [15:0]       rem_r, rem_nxt;
  logic [1:0]        op_r, op_nxt;
  logic              resp_r, resp_nxt;
  logic              up_r, up_nxt;
  logic [16:0]       ans_r, ans_nxt;
  logic              err_r, err_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_data_r, out_data_nxt;

  logic [11:0]       in_value;
  logic [15:0]       in_rank;
  logic              accept;
  logic              in_range;
  logic [COUNT_BITS-1:0] cnt;
  logic              miss;
  logic              clr_miss;
  logic              off_last;
  logic              v_last;
  logic [31:0]       clr_total;
  logic [17:0]       over_ans;
  logic [31:0]       total32;

  assign in_value  = in_tdata[11:0];
  assign in_rank   = in_tdata[27:12];
  assign accept    = in_tvalid && in_tready;
  assign in_range  = {20'd0, in_value} < 32'(VALUE_SPACE);
  assign cnt       = mem_rdata_r[COUNT_BITS-1:0];
  assign miss      = mem_rdata_r[COUNT_BITS];
  assign clr_miss  = (v_r != '0) && (32'(v_r) <= 32'(clr_limit_r));
  assign off_last  = (32'(v_r) & 32'(BLOCK_SIZE - 1)) == 32'(BLOCK_SIZE - 1);
  assign v_last    = 32'(v_r) == 32'(VALUE_SPACE - 1);
  assign clr_total = (32'(clr_limit_r) < 32'(VALUE_SPACE - 1)) ? 32'(clr_limit_r)
                                                               : 32'(VALUE_SPACE - 1);
  assign total32   = 32'(total_r);
  assign over_ans  = {6'd0, limit_r} + {2'd0, in_rank} - total32[17:0];

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (bs_we) bsm[bs_waddr] <= bs_wdata;
    if (bs_re) bs_rdata_r <= bsm[bs_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      limit_r     <= LIMIT_RST;
      clr_limit_r <= LIMIT_RST;
      v_r         <= '0;
      bcnt_r      <= '0;
      resp_r      <= 1'b0;
      out_valid_r <= 1'b0;
      total_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr_en) limit_r <= cfg_wr_data;
      clr_limit_r <= clr_limit_nxt;
      v_r         <= v_nxt;
      bcnt_r      <= bcnt_nxt;
      resp_r      <= resp_nxt;
      out_valid_r <= out_valid_nxt;
      total_r     <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r      <= blk_nxt;
    rem_r      <= rem_nxt;
    op_r       <= op_nxt;
    up_r       <= up_nxt;
    ans_r      <= ans_nxt;
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_limit_nxt = clr_limit_r;
    v_nxt         = v_r;
    blk_nxt       = blk_r;
    bcnt_nxt      = bcnt_r;
    rem_nxt       = rem_r;
    op_nxt        = op_r;
    resp_nxt      = resp_r;
    up_nxt        = up_r;
    ans_nxt       = ans_r;
    err_nxt       = err_r;
    total_nxt     = total_r;
    mem_we        = 1'b0;
    mem_waddr     = v_r;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = v_r;
    bs_we         = 1'b0;
    bs_waddr      = blk_r;
    bs_wdata      = '0;
    bs_re         = 1'b0;
    bs_raddr      = blk_r;
    unique case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_wdata = {clr_miss, {COUNT_BITS{1'b0}}};
        bcnt_nxt  = bcnt_r + BSUM_W'(clr_miss);
        if (off_last || v_last) begin
          bs_we    = 1'b1;
          bs_waddr = BLK_W'(v_r >> SH);
          bs_wdata = bcnt_r + BSUM_W'(clr_miss);
          bcnt_nxt = '0;
        end
        v_nxt = v_r + 1'b1;
        if (v_last) begin
          v_nxt     = '0;
          total_nxt = VAL_W'(clr_total);
          ans_nxt   = '0;
          err_nxt   = 1'b0;
          state_nxt = resp_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_nxt  = in_tuser;
          ans_nxt = '0;
          err_nxt = 1'b0;
          unique case (in_tuser)
            OP_ADD, OP_REM: begin
              if (in_range) begin
                v_nxt     = VAL_W'(in_value);
                mem_re    = 1'b1;
                mem_raddr = VAL_W'(in_value);
                state_nxt = S_RMW;
              end else begin
                err_nxt   = 1'b1;
                state_nxt = S_DONE;
              end
            end
            OP_QUERY: begin
              rem_nxt = in_rank;
              blk_nxt = '0;
              if (in_rank == '0) begin
                state_nxt = S_DONE;
              end else if (32'(in_rank) > total32) begin
                ans_nxt   = (over_ans > ANSWER_MAX) ? ANSWER_MAX[16:0] : over_ans[16:0];
                state_nxt = S_DONE;
              end else begin
                bs_re     = 1'b1;
                bs_raddr  = '0;
                state_nxt = S_QBLK;
              end
            end
            OP_CLEAR: begin
              clr_limit_nxt = limit_r;
              v_nxt         = '0;
              bcnt_nxt      = '0;
              resp_nxt      = 1'b1;
              state_nxt     = S_CLR;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_RMW: begin
        state_nxt = S_DONE;
        mem_waddr = v_r;
        bs_raddr  = BLK_W'(v_r >> SH);
        blk_nxt   = BLK_W'(v_r >> SH);
        if (op_r == OP_ADD) begin
          if (cnt == COUNT_MAX) begin
            err_nxt = 1'b1;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = {miss && (cnt != '0), cnt + 1'b1};
            if (cnt == '0 && miss) begin
              up_nxt    = 1'b0;
              bs_re     = 1'b1;
              state_nxt = S_BSUM;
            end
          end
        end else begin
          if (cnt == '0) begin
            err_nxt = 1'b1;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = {miss, cnt - 1'b1};
            if (cnt == COUNT_BITS'(1) && !miss && v_r != '0
                && 32'(v_r) <= 32'(limit_r)) begin
              mem_wdata = {1'b1, cnt - 1'b1};
              up_nxt    = 1'b1;
              bs_re     = 1'b1;
              state_nxt = S_BSUM;
            end
          end
        end
      end
      S_BSUM: begin
        bs_we     = 1'b1;
        bs_waddr  = blk_r;
        bs_wdata  = up_r ? bs_rdata_r + 1'b1 : bs_rdata_r - 1'b1;
        total_nxt = up_r ? total_r + 1'b1 : total_r - 1'b1;
        state_nxt = S_DONE;
      end
      S_QBLK: begin
        if (rem_r > 16'(bs_rdata_r)) begin
          rem_nxt = rem_r - 16'(bs_rdata_r);
          if (32'(blk_r) == 32'(NUM_BLOCKS - 1)) begin
            state_nxt = S_DONE;
          end else begin
            blk_nxt  = blk_r + 1'b1;
            bs_re    = 1'b1;
            bs_raddr = blk_r + 1'b1;
          end
        end else begin
          v_nxt     = VAL_W'(32'(blk_r) << SH);
          mem_re    = 1'b1;
          mem_raddr = VAL_W'(32'(blk_r) << SH);
          state_nxt = S_QENT;
        end
      end
      S_QENT: begin
        if (miss && rem_r == 16'd1) begin
          ans_nxt   = 17'(v_r);
          state_nxt = S_DONE;
        end else begin
          if (miss) rem_nxt = rem_r - 1'b1;
          if (off_last || v_last) begin
            state_nxt = S_DONE;
          end else begin
            v_nxt     = v_r + 1'b1;
            mem_re    = 1'b1;
            mem_raddr = v_r + 1'b1;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          resp_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = state_r == S_IDLE;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {2'd0, err_r, total32[11:0], ans_r};
    end
    out_tvalid = out_valid_r;
    out_tdata  = out_data_r;
  end

  `KMVT_AST_NEXT(a_rmw_follows, accept && in_range && (in_tuser == OP_ADD || in_tuser == OP_REM), state_r == S_RMW, "add or remove did not start read-modify-write")
  `KMVT_AST_IMPL(a_total_bound, 1'b1, 32'(total_r) <= 32'(VALUE_SPACE - 1), "missing total out of range")
  `KMVT_AST_IMPL(a_no_req_in_clear, state_r == S_CLR, !in_tready, "request taken during clear sweep")
  `KMVT_AST_IMPL(a_rank_live, state_r == S_QENT, rem_r != 16'd0, "entry scan with zero rank left")

endmodule

// ===== tb/sv/kth_missing_value_tracker_test.sv =====
module kth_missing_value_tracker_test;
  import kmvt_pkg::*;

  localparam int NVAL = 4096;
  localparam int BSZ = 64;
  localparam int NBLK = NVAL / BSZ;
  localparam int CMAX = 65535;

  typedef struct packed {
    logic [16:0] answer;
    logic [11:0] missing_total;
    logic        error;
  } tracker_result_t;

  class missing_value_book;
    int unsigned count[NVAL];
    bit          miss[NVAL];
    int unsigned blk_sum[NBLK];
    int unsigned total;
    int unsigned limit;
    tracker_result_t pending[$];
    int mismatches;
    int results_seen;

    function new();
      limit = 32'(LIMIT_RST);
      mismatches = 0;
      results_seen = 0;
      rebuild();
    endfunction

    function void rebuild();
      foreach (count[i]) count[i] = 0;
      foreach (miss[i]) miss[i] = 0;
      foreach (blk_sum[i]) blk_sum[i] = 0;
      total = 0;
      for (int v = 1; v <= limit && v < NVAL; v++) begin
        miss[v] = 1;
        blk_sum[v / BSZ]++;
        total++;
      end
    endfunction

    function int unsigned kth_missing(int unsigned k);
      int unsigned blk;
      int unsigned rest;
      longint unsigned over;
      blk = 0;
      rest = k;
      if (k == 0) return 0;
      if (k > total) begin
        over = longint'(limit) + longint'(k - total);
        return (over > 'h1FFFF) ? 'h1FFFF : 32'(over);
      end
      while (blk < NBLK && rest > blk_sum[blk]) begin
        rest -= blk_sum[blk];
        blk++;
      end
      if (blk >= NBLK) return 0;
      for (int v = blk * BSZ; v < (blk + 1) * BSZ; v++) begin
        if (miss[v]) begin
          rest--;
          if (rest == 0) return v;
        end
      end
      return 0;
    endfunction

    function void note_request(logic [1:0] op, logic [11:0] value, logic [15:0] rank);
      tracker_result_t r;
      int v;
      v = int'(value);
      r = '0;
      case (op)
        OP_ADD: begin
          if (count[v] >= CMAX) r.error = 1'b1;
          else begin
            if (count[v] == 0 && miss[v]) begin
              miss[v] = 0;
              blk_sum[v / BSZ]--;
              total--;
            end
            count[v]++;
          end
        end
        OP_REM: begin
          if (count[v] == 0) r.error = 1'b1;
          else begin
            if (count[v] == 1 && !miss[v] && v >= 1 && v <= limit) begin
              miss[v] = 1;
              blk_sum[v / BSZ]++;
              total++;
            end
            count[v]--;
          end
        end
        OP_QUERY: r.answer = 17'(kth_missing(32'(rank)));
        default: rebuild();
      endcase
      r.missing_total = total[11:0];
      pending = {pending, r};
    endfunction

    function void check_result(logic [31:0] data);
      tracker_result_t exp_r;
      tracker_result_t got;
      got.answer = data[16:0];
      got.missing_total = data[28:17];
      got.error = data[29];
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", data);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: answer exp %0d got %0d, total exp %0d got %0d, err exp %0d got %0d",
                   exp_r.answer, got.answer, exp_r.missing_total, got.missing_total,
                   exp_r.error, got.error);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_wr_en = 0;
  logic [11:0] cfg_wr_data = '0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [31:0] out_tdata;

  missing_value_book book;
  int stall_left = 0;
  bit steady_out = 0;
  bit steady_in = 0;
  int clears = 0;
  int queries = 0;
  int limit_writes = 0;

  always #10 clk = ~clk;

  kth_missing_value_tracker i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  function automatic int pick_gap();
    int p;
    p = int'($urandom_range(0, 99));
    if (p < 60) return 0;
    if (p < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(10, 60));
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
    end else begin
      if (out_tvalid && out_tready) book.check_result(out_tdata);
      if (steady_out) begin
        out_tready <= 1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_tready <= 0;
      end else begin
        stall_left <= pick_gap();
        out_tready <= 1;
      end
    end
  end

  task automatic send_request(logic [1:0] op, logic [11:0] value, logic [15:0] rank);
    int gap;
    gap = steady_in ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= op;
    in_tdata <= {4'b0, rank, value};
    do @(posedge clk); while (!in_tready);
    book.note_request(op, value, rank);
    if (op == OP_CLEAR) clears++;
    if (op == OP_QUERY) queries++;
  endtask

  task automatic drain_results();
    in_tvalid <= 0;
    while (book.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(logic [11:0] lim);
    drain_results();
    repeat (3) @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= lim;
    @(posedge clk);
    cfg_wr_en <= 0;
    book.limit = 32'(lim);
    limit_writes++;
  endtask

  function automatic logic [11:0] pick_value();
    int p;
    p = int'($urandom_range(0, 99));
    if (p < 10) return 12'($urandom_range(0, 4095));
    if (p < 15) return 12'd0;
    if (p < 55) return 12'($urandom_range(0, 40));
    if (p < 80) return (book.limit + $urandom_range(0, 6) >= 6) ?
                       12'(book.limit + $urandom_range(0, 6) - 3) : 12'($urandom_range(0, 8));
    return 12'($urandom_range(100, 260));
  endfunction

  function automatic logic [15:0] pick_rank();
    int p;
    p = int'($urandom_range(0, 99));
    if (p < 50) return 16'($urandom_range(0, book.total + 4));
    if (p < 70) return 16'($urandom_range(0, 65535));
    if (p < 80) return 16'(book.total);
    if (p < 90) return 16'($urandom_range(0, 70));
    return 16'(65535 - $urandom_range(0, 3));
  endfunction

  task automatic random_request();
    int p;
    p = int'($urandom_range(0, 199));
    if (p < 80) send_request(OP_ADD, pick_value(), 16'($urandom_range(0, 65535)));
    else if (p < 130) send_request(OP_REM, pick_value(), 16'($urandom_range(0, 65535)));
    else if (p < 197) send_request(OP_QUERY, 12'($urandom_range(0, 4095)), pick_rank());
    else send_request(OP_CLEAR, 12'($urandom_range(0, 4095)), 16'($urandom_range(0, 65535)));
  endtask

  initial begin
    book = new();
    repeat (7) @(posedge clk);
    rst_n <= 1;

    // directed
    send_request(OP_QUERY, 12'd0, 16'd0);
    send_request(OP_QUERY, 12'hFFF, 16'd1);
    send_request(OP_QUERY, 12'd0, 16'd4095);
    send_request(OP_QUERY, 12'd0, 16'hFFFF);
    send_request(OP_REM, 12'd5, 16'd0);
    send_request(OP_ADD, 12'd0, 16'd0);
    send_request(OP_ADD, 12'hFFF, 16'hFFFF);
    send_request(OP_ADD, 12'd1, 16'd0);
    send_request(OP_ADD, 12'd1, 16'd0);
    send_request(OP_QUERY, 12'd0, 16'd1);
    send_request(OP_REM, 12'd1, 16'd0);
    send_request(OP_REM, 12'd1, 16'd0);
    send_request(OP_REM, 12'd1, 16'd0);
    send_request(OP_REM, 12'hFFF, 16'd0);
    write_limit(12'd1);
    send_request(OP_QUERY, 12'd0, 16'hFFFF);
    send_request(OP_CLEAR, 12'd0, 16'd0);
    send_request(OP_ADD, 12'd2, 16'd0);
    send_request(OP_REM, 12'd2, 16'd0);
    send_request(OP_QUERY, 12'd0, 16'd1);
    send_request(OP_QUERY, 12'd0, 16'd2);
    write_limit(12'd4095);
    send_request(OP_QUERY, 12'd0, 16'd70);
    send_request(OP_CLEAR, 12'd0, 16'd0);
    send_request(OP_QUERY, 12'd0, 16'd64);

    // back to back adds on one value
    steady_in = 1;
    steady_out = 1;
    for (int i = 0; i < 40; i++) send_request(OP_ADD, 12'd7, 16'd0);
    send_request(OP_QUERY, 12'd0, 16'd7);
    send_request(OP_CLEAR, 12'd0, 16'd0);
    steady_in = 0;
    steady_out = 0;

    for (int n = 0; n < 1280; n++) begin
      if (n % 150 == 149) begin
        case ($urandom_range(0, 3))
          0: write_limit(12'd1);
          1: write_limit(12'd4095);
          2: write_limit(12'($urandom_range(1, 4095)));
          default: write_limit(12'($urandom_range(1, 200)));
        endcase
        if ($urandom_range(0, 1)) send_request(OP_CLEAR, 12'd0, 16'd0);
      end
      steady_in = (n % 400) >= 300 && (n % 400) < 340;
      steady_out = (n % 500) >= 420 && (n % 500) < 460;
      random_request();
    end
    steady_in = 0;
    steady_out = 0;
    in_tvalid <= 0;

    for (int w = 0; w < 100000 && book.pending.size() != 0; w++) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("covered %0d results, %0d queries, %0d clears, %0d limit writes",
             book.results_seen, queries, clears, limit_writes);
    if (book.mismatches == 0 && book.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results missing", book.mismatches, book.pending.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #400000000;
    $display("timeout");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
